@@ rtl/gtag_pkg.sv @@
// Shared types, codes and default sizes for the GEMM tile address generator.
package gtag_pkg;

    // Default systolic array and accumulator sizes
    localparam int DEF_ARRAY_HEIGHT = 128;
    localparam int DEF_ARRAY_WIDTH  = 128;
    localparam int DEF_ACC_DEPTH    = 2048;

    localparam int DIM_W  = 16;
    localparam int ADDR_W = 32;
    localparam int ID_W   = 31;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 208;

    // Input item kinds carried in s_tuser
    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // Fields latched by a start transaction
    typedef struct packed {
        logic [DIM_W-1:0]  rows_a;
        logic [DIM_W-1:0]  inner_b;
        logic [DIM_W-1:0]  cols_c;
        logic              planar_layout;
        logic [DIM_W-1:0]  channels;
        logic [ADDR_W-1:0] weight_base;
        logic [ADDR_W-1:0] activation_base;
    } start_fields_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch dimensions, clear tile walk
        logic sum;     // register the offset sums
        logic mul_w;   // scale weight offset by the stride factor
        logic mul_a;   // scale activation offset by the stride factor
        logic emit;    // load output register and step the tile walk
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fin;       // current tile pair is the final one
        logic out_full;  // output register still holds an untaken result
    } dp_sts_t;

endpackage

@@ rtl/gemm_tile_address_generator.sv @@
// Top level of the GEMM tile address generator: stream ports, controller and datapath.
//
// A start transaction (s_tuser = 0) latches the matrix sizes, layout factor and base
// addresses and produces no result. Each advance transaction (s_tuser = 1)
// produces one weight/activation tile pair, in row-tile, column-tile, inner-tile order,
// with m_tlast on the final pair; an advance with no product running is dropped.
// An accepted advance passes through the offset sums, then the weight and activation
// address scalings, which share one 32x16 multiplier, then the load of the output
// register. The next item is accepted in the cycle after the result is loaded, so
// no advance is taken before the last one's result is loaded, though that result may
// still wait on m_tready; a second result waits in the last step until the output
// register is free. Tile ids run from 1 and skip 0 when they wrap.
module gemm_tile_address_generator #(
    parameter int ARRAY_HEIGHT = gtag_pkg::DEF_ARRAY_HEIGHT,
    parameter int ARRAY_WIDTH  = gtag_pkg::DEF_ARRAY_WIDTH,
    parameter int ACC_DEPTH    = gtag_pkg::DEF_ACC_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rows_a[15:0], inner_b[31:16], cols_c[47:32], planar_layout[48],
    // channels[64:49], weight_base[96:65], activation_base[128:97], zero pad
    input  logic [gtag_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tile_id[30:0], weight_address[62:31], weight_width[78:63], weight_height[94:79],
    // activation_address[126:95], activation_width[142:127],
    // activation_height[158:143], stride_factor[174:159], full_width[190:175],
    // full_height[206:191], zero pad
    output logic [gtag_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    gtag_pkg::dp_cmd_t       cmd;
    gtag_pkg::dp_sts_t       sts;
    gtag_pkg::start_fields_t start_fields;

    logic [gtag_pkg::ID_W-1:0]   tile_id;
    logic [gtag_pkg::ADDR_W-1:0] weight_address, activation_address;
    logic [gtag_pkg::DIM_W-1:0]  weight_width, weight_height;
    logic [gtag_pkg::DIM_W-1:0]  activation_width, activation_height;
    logic [gtag_pkg::DIM_W-1:0]  stride_factor, full_width, full_height;

    // Unpack the start fields
    assign start_fields.rows_a          = s_tdata[15:0];
    assign start_fields.inner_b         = s_tdata[31:16];
    assign start_fields.cols_c          = s_tdata[47:32];
    assign start_fields.planar_layout   = s_tdata[48];
    assign start_fields.channels        = s_tdata[64:49];
    assign start_fields.weight_base     = s_tdata[96:65];
    assign start_fields.activation_base = s_tdata[128:97];

    // Pack the result
    assign m_tdata = {1'b0, full_height, full_width, stride_factor, activation_height,
                      activation_width, activation_address, weight_height, weight_width,
                      weight_address, tile_id};

    gtag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    gtag_datapath #(
        .ARRAY_HEIGHT (ARRAY_HEIGHT),
        .ARRAY_WIDTH  (ARRAY_WIDTH),
        .ACC_DEPTH    (ACC_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .start_fields       (start_fields),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tlast            (m_tlast),
        .tile_id            (tile_id),
        .weight_address     (weight_address),
        .weight_width       (weight_width),
        .weight_height      (weight_height),
        .activation_address (activation_address),
        .activation_width   (activation_width),
        .activation_height  (activation_height),
        .stride_factor      (stride_factor),
        .full_width         (full_width),
        .full_height        (full_height)
    );

endmodule

@@ rtl/gtag_ctrl.sv @@
// Controller state machine: accepts items and sequences the datapath per tile pair.
module gtag_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tuser,
    output gtag_pkg::dp_cmd_t   cmd,
    input  gtag_pkg::dp_sts_t   sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_W,
        ST_MUL_A,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   in_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Decode next state and datapath commands
    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (gtag_pkg::op_t'(s_tuser) == gtag_pkg::OP_START) begin
                        cmd.start = 1'b1;
                        busy_next = 1'b1;
                    end else if (busy_reg) begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.mul_w  = 1'b1;
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Wait until the output register can take the result
                if (!sts.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                    if (sts.fin) begin
                        busy_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

@@ rtl/gtag_datapath.sv @@
// Datapath: latched product setup, tile walk, shared address multiplier, output register.
module gtag_datapath #(
    parameter int ARRAY_HEIGHT = gtag_pkg::DEF_ARRAY_HEIGHT,
    parameter int ARRAY_WIDTH  = gtag_pkg::DEF_ARRAY_WIDTH,
    parameter int ACC_DEPTH    = gtag_pkg::DEF_ACC_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gtag_pkg::dp_cmd_t             cmd,
    output gtag_pkg::dp_sts_t             sts,
    input  gtag_pkg::start_fields_t       start_fields,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_tlast,
    output logic [gtag_pkg::ID_W-1:0]     tile_id,
    output logic [gtag_pkg::ADDR_W-1:0]   weight_address,
    output logic [gtag_pkg::DIM_W-1:0]    weight_width,
    output logic [gtag_pkg::DIM_W-1:0]    weight_height,
    output logic [gtag_pkg::ADDR_W-1:0]   activation_address,
    output logic [gtag_pkg::DIM_W-1:0]    activation_width,
    output logic [gtag_pkg::DIM_W-1:0]    activation_height,
    output logic [gtag_pkg::DIM_W-1:0]    stride_factor,
    output logic [gtag_pkg::DIM_W-1:0]    full_width,
    output logic [gtag_pkg::DIM_W-1:0]    full_height
);

    localparam int DW = gtag_pkg::DIM_W;
    localparam int AW = gtag_pkg::ADDR_W;
    localparam int IW = gtag_pkg::ID_W;

    // Tile sizes one bit wider than a dimension so that 65536 still fits
    localparam logic [DW:0]   AH_SZ   = (DW+1)'(ARRAY_HEIGHT);
    localparam logic [DW:0]   AW_SZ   = (DW+1)'(ARRAY_WIDTH);
    localparam logic [DW:0]   AD_SZ   = (DW+1)'(ACC_DEPTH);
    localparam logic [AW-1:0] AW_STEP = AW'(ARRAY_WIDTH);
    localparam logic [AW-1:0] AD_STEP = AW'(ACC_DEPTH);
    localparam logic [AW-1:0] AH_MUL  = AW'(ARRAY_HEIGHT);
    localparam logic [IW-1:0] ID_ONE  = IW'(1);

    // Latched product setup
    logic [DW-1:0] dim_a_reg, dim_b_reg, dim_c_reg, factor_reg;
    logic [AW-1:0] wbase_reg, abase_reg;
    logic [AW-1:0] w_row_step_reg, a_inner_step_reg;

    // Tile walk: remaining extent per dimension and unscaled offsets
    logic [DW-1:0] rem_a_reg, rem_a_next;
    logic [DW-1:0] rem_b_reg, rem_b_next;
    logic [DW-1:0] rem_c_reg, rem_c_next;
    logic [AW-1:0] w_row_off_reg, w_row_off_next;
    logic [AW-1:0] w_inner_off_reg, w_inner_off_next;
    logic [AW-1:0] a_inner_off_reg, a_inner_off_next;
    logic [AW-1:0] a_col_off_reg, a_col_off_next;

    // Arithmetic pipeline
    logic [AW-1:0]      w_sum_reg, a_sum_reg;
    logic [AW-1:0]      w_prod_reg, a_prod_reg;
    logic [AW-1:0]      mul_in;
    logic [AW+DW-1:0]   mul_full;

    // Running id and output register
    logic [IW-1:0] next_id_reg, next_id_inc;
    logic          out_valid_reg;
    logic          last_a, last_b, last_c, fin;
    logic [DW-1:0] edge_a, edge_b, edge_c;

    // Last tile of a dimension when what is left fits in one tile
    assign last_a = ({1'b0, rem_a_reg} <= AH_SZ);
    assign last_b = ({1'b0, rem_b_reg} <= AW_SZ);
    assign last_c = ({1'b0, rem_c_reg} <= AD_SZ);
    assign fin    = last_a && last_b && last_c;

    assign edge_a = last_a ? rem_a_reg : AH_SZ[DW-1:0];
    assign edge_b = last_b ? rem_b_reg : AW_SZ[DW-1:0];
    assign edge_c = last_c ? rem_c_reg : AD_SZ[DW-1:0];

    assign sts.fin      = fin;
    assign sts.out_full = out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;

    // One 32x16 multiplier shared by both addresses
    assign mul_in   = cmd.mul_a ? a_sum_reg : w_sum_reg;
    assign mul_full = mul_in * factor_reg;

    assign next_id_inc = (next_id_reg == {IW{1'b1}}) ? ID_ONE : next_id_reg + ID_ONE;

    // Step the tile walk: inner fastest, then column, then row
    always_comb begin
        rem_a_next       = rem_a_reg;
        rem_b_next       = rem_b_reg;
        rem_c_next       = rem_c_reg;
        w_row_off_next   = w_row_off_reg;
        w_inner_off_next = w_inner_off_reg;
        a_inner_off_next = a_inner_off_reg;
        a_col_off_next   = a_col_off_reg;
        if (!last_b) begin
            rem_b_next       = DW'({1'b0, rem_b_reg} - AW_SZ);
            w_inner_off_next = w_inner_off_reg + AW_STEP;
            a_inner_off_next = a_inner_off_reg + a_inner_step_reg;
        end else begin
            rem_b_next       = dim_b_reg;
            w_inner_off_next = '0;
            a_inner_off_next = '0;
            if (!last_c) begin
                rem_c_next     = DW'({1'b0, rem_c_reg} - AD_SZ);
                a_col_off_next = a_col_off_reg + AD_STEP;
            end else begin
                rem_c_next     = dim_c_reg;
                a_col_off_next = '0;
                rem_a_next     = DW'({1'b0, rem_a_reg} - AH_SZ);
                w_row_off_next = w_row_off_reg + w_row_step_reg;
            end
        end
    end

    // Control registers: id and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_id_reg   <= ID_ONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                next_id_reg   <= next_id_inc;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            dim_a_reg        <= start_fields.rows_a;
            dim_b_reg        <= start_fields.inner_b;
            dim_c_reg        <= start_fields.cols_c;
            factor_reg       <= start_fields.planar_layout ? DW'(1) : start_fields.channels;
            wbase_reg        <= start_fields.weight_base;
            abase_reg        <= start_fields.activation_base;
            w_row_step_reg   <= AH_MUL * AW'(start_fields.inner_b);
            a_inner_step_reg <= AW_STEP * AW'(start_fields.cols_c);
            rem_a_reg        <= start_fields.rows_a;
            rem_b_reg        <= start_fields.inner_b;
            rem_c_reg        <= start_fields.cols_c;
            w_row_off_reg    <= '0;
            w_inner_off_reg  <= '0;
            a_inner_off_reg  <= '0;
            a_col_off_reg    <= '0;
        end else if (cmd.emit) begin
            rem_a_reg        <= fin ? dim_a_reg : rem_a_next;
            rem_b_reg        <= fin ? dim_b_reg : rem_b_next;
            rem_c_reg        <= fin ? dim_c_reg : rem_c_next;
            w_row_off_reg    <= fin ? '0 : w_row_off_next;
            w_inner_off_reg  <= fin ? '0 : w_inner_off_next;
            a_inner_off_reg  <= fin ? '0 : a_inner_off_next;
            a_col_off_reg    <= fin ? '0 : a_col_off_next;
        end

        if (cmd.sum) begin
            w_sum_reg <= w_row_off_reg + w_inner_off_reg;
            a_sum_reg <= a_inner_off_reg + a_col_off_reg;
        end
        if (cmd.mul_w) begin
            w_prod_reg <= mul_full[AW-1:0];
        end
        if (cmd.mul_a) begin
            a_prod_reg <= mul_full[AW-1:0];
        end

        // Load the result
        if (cmd.emit) begin
            tile_id            <= next_id_reg;
            weight_address     <= wbase_reg + w_prod_reg;
            weight_width       <= edge_b;
            weight_height      <= edge_a;
            activation_address <= abase_reg + a_prod_reg;
            activation_width   <= edge_c;
            activation_height  <= edge_a;
            stride_factor      <= factor_reg;
            full_width         <= dim_b_reg;
            full_height        <= dim_a_reg;
            m_tlast            <= fin;
        end
    end

endmodule

@@ rtl/gtag_checker.sv @@
// Port-level checker for the GEMM tile address generator, bound to the top level.
module gtag_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gtag_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Tile id never reads zero
    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[30:0] != 31'd0)
        else $error("tile id is zero");

    // Both tiles of a pair share one height
    a_same_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[94:79] == m_tdata[158:143])
        else $error("weight and activation heights differ");

    // Weight tile sizes never exceed the full matrix
    a_fits_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[78:63] <= m_tdata[190:175])
                  && (m_tdata[94:79] <= m_tdata[206:191]))
        else $error("tile larger than matrix");

endmodule

bind gemm_tile_address_generator gtag_checker u_gtag_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ verif/tb_gemm_tile_address_generator.sv @@
// Self-checking testbench for the GEMM tile address generator: stream stimulus and tile walk scoreboard.
module tb_gemm_tile_address_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_OFF    = 300;

    // Result layout on m_tdata, last field first
    typedef struct packed {
        logic                      pad;
        logic [15:0]               full_height;
        logic [15:0]               full_width;
        logic [15:0]               stride_factor;
        logic [15:0]               activation_height;
        logic [15:0]               activation_width;
        logic [31:0]               activation_address;
        logic [15:0]               weight_height;
        logic [15:0]               weight_width;
        logic [31:0]               weight_address;
        logic [gtag_pkg::ID_W-1:0] tile_id;
    } tile_pair_t;

    typedef struct {
        tile_pair_t pair;
        logic       last;
    } expected_pair_t;

    // Tracks the tile walk and holds the tile pairs still owed by the block
    class tile_walk_checker;
        bit [gtag_pkg::ID_W-1:0] next_id;
        bit             active;
        int unsigned    row_t;
        int unsigned    col_t;
        int unsigned    inner_t;
        bit [15:0]      dim_a;
        bit [15:0]      dim_b;
        bit [15:0]      dim_c;
        bit [15:0]      factor;
        bit [31:0]      w_base;
        bit [31:0]      a_base;
        expected_pair_t pending_pairs[$];
        int             errors;

        function new();
            next_id = 1;
            active  = 0;
            row_t   = 0;
            col_t   = 0;
            inner_t = 0;
            dim_a   = 0;
            dim_b   = 0;
            dim_c   = 0;
            factor  = 1;
            w_base  = 0;
            a_base  = 0;
            errors  = 0;
        endfunction

        // Ceiling tile count; an empty dimension still makes one tile
        static function int unsigned tiles(bit [15:0] dim, int unsigned size);
            if (dim == 0) return 1;
            return (dim - 1) / size + 1;
        endfunction

        static function int unsigned edge_of(bit [15:0] dim, int unsigned size,
                                             int unsigned idx, int unsigned cnt);
            if (idx + 1 == cnt) return dim - (cnt - 1) * size;
            return size;
        endfunction

        // Note one accepted input transaction and queue the tile pair that an advance yields
        function void note_item(logic op, logic [gtag_pkg::S_TDATA_W-1:0] d);
            int unsigned       na;
            int unsigned       nb;
            int unsigned       nc;
            longint unsigned   off_w;
            longint unsigned   off_a;
            expected_pair_t    e;
            bit                fin;
            if (op == gtag_pkg::OP_START) begin
                dim_a   = d[15:0];
                dim_b   = d[31:16];
                dim_c   = d[47:32];
                factor  = d[48] ? 16'd1 : d[64:49];
                w_base  = d[96:65];
                a_base  = d[128:97];
                row_t   = 0;
                col_t   = 0;
                inner_t = 0;
                active  = 1;
                return;
            end
            // Drop an advance with no product running
            if (!active) return;
            na = tiles(dim_a, gtag_pkg::DEF_ARRAY_HEIGHT);
            nb = tiles(dim_b, gtag_pkg::DEF_ARRAY_WIDTH);
            nc = tiles(dim_c, gtag_pkg::DEF_ACC_DEPTH);
            off_w = 64'(row_t) * gtag_pkg::DEF_ARRAY_HEIGHT * dim_b
                  + 64'(inner_t) * gtag_pkg::DEF_ARRAY_WIDTH;
            off_a = 64'(inner_t) * gtag_pkg::DEF_ARRAY_WIDTH * dim_c
                  + 64'(col_t) * gtag_pkg::DEF_ACC_DEPTH;
            fin = (row_t + 1 == na) && (col_t + 1 == nc) && (inner_t + 1 == nb);
            e.pair.pad                = 1'b0;
            e.pair.tile_id            = next_id;
            e.pair.weight_address     = 32'(w_base + factor * off_w);
            e.pair.weight_width       = 16'(edge_of(dim_b, gtag_pkg::DEF_ARRAY_WIDTH,
                                                    inner_t, nb));
            e.pair.weight_height      = 16'(edge_of(dim_a, gtag_pkg::DEF_ARRAY_HEIGHT,
                                                    row_t, na));
            e.pair.activation_address = 32'(a_base + factor * off_a);
            e.pair.activation_width   = 16'(edge_of(dim_c, gtag_pkg::DEF_ACC_DEPTH,
                                                    col_t, nc));
            e.pair.activation_height  = e.pair.weight_height;
            e.pair.stride_factor      = factor;
            e.pair.full_width         = dim_b;
            e.pair.full_height        = dim_a;
            e.last                    = fin;
            pending_pairs.insert(pending_pairs.size(), e);
            // Advance the id, skipping zero on wrap
            next_id = next_id + 1;
            if (next_id == 0) next_id = 1;
            // Step the walk: inner tile fastest, then column, then row
            if (fin) begin
                active  = 0;
                row_t   = 0;
                col_t   = 0;
                inner_t = 0;
            end else if (inner_t + 1 < nb) begin
                inner_t++;
            end else begin
                inner_t = 0;
                if (col_t + 1 < nc) begin
                    col_t++;
                end else begin
                    col_t = 0;
                    row_t++;
                end
            end
        endfunction

        static function logic [31:0] field_of(tile_pair_t p, logic l, int k);
            case (k)
                0: return 32'(p.tile_id);
                1: return p.weight_address;
                2: return 32'(p.weight_width);
                3: return 32'(p.weight_height);
                4: return p.activation_address;
                5: return 32'(p.activation_width);
                6: return 32'(p.activation_height);
                7: return 32'(p.stride_factor);
                8: return 32'(p.full_width);
                9: return 32'(p.full_height);
                default: return 32'(l);
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one received tile pair with the oldest one owed
        task check_pair(tile_pair_t got, logic got_last);
            expected_pair_t e;
            string names[11] = '{"tile_id", "weight_address", "weight_width",
                                 "weight_height", "activation_address", "activation_width",
                                 "activation_height", "stride_factor", "full_width",
                                 "full_height", "last"};
            if (pending_pairs.size() == 0) begin
                report($sformatf("tile pair id %0d with none expected", got.tile_id));
                return;
            end
            e = pending_pairs.pop_front();
            for (int k = 0; k < 11; k++) begin
                if (field_of(got, got_last, k) !== field_of(e.pair, e.last, k)) begin
                    report($sformatf("id %0d %s: got %h, want %h", e.pair.tile_id, names[k],
                                     field_of(got, got_last, k), field_of(e.pair, e.last, k)));
                end
            end
        endtask
    endclass

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gtag_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gtag_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    tile_walk_checker walk = new();

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_cycles  = 0;
    int quiet_cycles = 0;
    int n_sent       = 0;

    gemm_tile_address_generator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: long hold-off when requested, else random back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor both channels and watch for a stuck block
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) walk.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) walk.check_pair(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one transaction, with an occasional gap, and wait for acceptance
    task automatic send_item(gtag_pkg::op_t op, logic [gtag_pkg::S_TDATA_W-1:0] data);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic send_start(bit [15:0] a, bit [15:0] b, bit [15:0] c, bit planar,
                              bit [15:0] ch, bit [31:0] wb, bit [31:0] ab);
        send_item(gtag_pkg::OP_START, {7'd0, ab, wb, ch, planar, c, b, a});
    endtask

    // Advance payload is ignored by the block; fill it with noise
    task automatic send_advance(int unsigned count);
        logic [159:0] junk;
        repeat (count) begin
            junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
            send_item(gtag_pkg::OP_ADVANCE, junk[gtag_pkg::S_TDATA_W-1:0]);
        end
    endtask

    // Hold the sender until every owed tile pair has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (walk.pending_pairs.size() != 0) @(posedge aclk);
    endtask

    // Mostly small sizes, with exact multiples, one-over edges and empty dims
    function automatic bit [15:0] pick_dim(int unsigned size);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 15) return 16'(size * $urandom_range(1, 2));
        if (r < 25) return 16'(size * $urandom_range(0, 2) + 1);
        return 16'($urandom_range(1, size * 2 + size / 2));
    endfunction

    // Full product, sometimes cut short by the next start
    task automatic run_product(bit cut);
        bit [15:0]   a;
        bit [15:0]   b;
        bit [15:0]   c;
        int unsigned total;
        a = pick_dim(gtag_pkg::DEF_ARRAY_HEIGHT);
        b = pick_dim(gtag_pkg::DEF_ARRAY_WIDTH);
        c = pick_dim(gtag_pkg::DEF_ACC_DEPTH);
        total = tile_walk_checker::tiles(a, gtag_pkg::DEF_ARRAY_HEIGHT)
              * tile_walk_checker::tiles(b, gtag_pkg::DEF_ARRAY_WIDTH)
              * tile_walk_checker::tiles(c, gtag_pkg::DEF_ACC_DEPTH);
        send_start(a, b, c, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                   $urandom, $urandom);
        send_advance(cut ? $urandom_range(0, total - 1) : total);
    endtask

    task automatic random_phase(int count);
        int stop_at;
        int r;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                run_product(1'b0);
            end else if (r < 80) begin
                run_product(1'b1);
            end else if (r < 90) begin
                send_advance($urandom_range(1, 3));
            end else begin
                // Full-range sizes: only the first few tiles are walked
                send_start(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                           16'($urandom_range(65535)), 1'($urandom_range(1)),
                           16'($urandom_range(65535)), $urandom, $urandom);
                send_advance($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles a third of the time, receiver two thirds
        tx_idle_pct = 33;
        rx_idle_pct = 68;

        // Advance with nothing running
        send_advance(1);
        // Single-tile product, then an advance past its end
        send_start(16'd1, 16'd1, 16'd1, 1'b1, 16'd5, 32'h0, 32'h0);
        send_advance(2);
        // Empty dimensions with a zero channel factor
        send_start(16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 32'h1234_5678, 32'h8765_4321);
        send_advance(1);
        // One-over edges in every dimension, widest factor, addresses wrap
        send_start(16'd129, 16'd129, 16'd2049, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
        send_advance(8);
        // Largest sizes, dropped by a new start part way through
        send_start(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'd3, 32'h0, 32'hFFFF_FFFF);
        send_advance(2);
        send_start(16'd300, 16'd5, 16'd1, 1'b1, 16'hFFFF, 32'hAAAA_5555, 32'h5555_AAAA);
        send_advance(3);
        drain();

        random_phase(420);
        drain();

        tx_idle_pct = 68;
        rx_idle_pct = 33;
        random_phase(420);
        drain();

        // No idling: stall the receiver while a 20-tile product streams in
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_start(16'd640, 16'd512, 16'd1, 1'b0, 16'd7, $urandom, $urandom);
        hold_cycles = HOLD_OFF;
        send_advance(20);
        drain();
        random_phase(400);
        drain();

        repeat (20) @(posedge aclk);
        if (walk.pending_pairs.size() != 0)
            walk.report($sformatf("%0d tile pairs never arrived", walk.pending_pairs.size()));
        if (walk.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ gemm_tile_address_generator.f @@
rtl/gtag_pkg.sv
rtl/gtag_ctrl.sv
rtl/gtag_datapath.sv
rtl/gemm_tile_address_generator.sv
rtl/gtag_checker.sv
verif/tb_gemm_tile_address_generator.sv
